// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file rau_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("fail");
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("fail");
`endif

// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [4:0] DP_NONE   = 5'd0;
  localparam logic [4:0] DP_LOAD   = 5'd1;
  localparam logic [4:0] DP_G1INIT = 5'd2;
  localparam logic [4:0] DP_DIVST  = 5'd3;
  localparam logic [4:0] DP_G1STEP = 5'd4;
  localparam logic [4:0] DP_LSET   = 5'd5;
  localparam logic [4:0] DP_MULST  = 5'd6;
  localparam logic [4:0] DP_T1SET  = 5'd7;
  localparam logic [4:0] DP_T2SET  = 5'd8;
  localparam logic [4:0] DP_COMB   = 5'd9;
  localparam logic [4:0] DP_G2INIT = 5'd10;
  localparam logic [4:0] DP_G2STEP = 5'd11;
  localparam logic [4:0] DP_NUMQ   = 5'd12;
  localparam logic [4:0] DP_DENQ   = 5'd13;
  localparam logic [4:0] DP_FINISH = 5'd14;
  localparam logic [4:0] DP_CROSS  = 5'd15;
  localparam logic [4:0] DP_GSET   = 5'd16;
  localparam logic [4:0] DP_Q1SET  = 5'd17;
  localparam logic [4:0] DP_Q2SET  = 5'd18;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] div_sel;
    logic [2:0] mul_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic bad;
    logic is_addsub;
    logic is_div;
    logic rem_zero;
  } dp_status_t;

  localparam logic [2:0] DIV_GCD = 3'd0;
  localparam logic [2:0] DIV_NUM = 3'd1;
  localparam logic [2:0] DIV_DEN = 3'd2;
  localparam logic [2:0] DIV_AD  = 3'd3;
  localparam logic [2:0] DIV_BD  = 3'd4;

  localparam logic [2:0] MUL_AN_BN = 3'd0;
  localparam logic [2:0] MUL_AD_BD = 3'd1;
  localparam logic [2:0] MUL_AN_BD = 3'd2;
  localparam logic [2:0] MUL_AD_BN = 3'd3;
  localparam logic [2:0] MUL_Q1_BD = 3'd4;
  localparam logic [2:0] MUL_Q2_AN = 3'd5;
  localparam logic [2:0] MUL_Q1_BN = 3'd6;
endpackage

// ===== rtl/core/rau_divider.sv =====
module rau_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic [63:0] remainder
);
  logic [6:0]  count;
  logic        busy;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dsr;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd0;
        rem <= '0;
        quo <= dividend;
        dsr <= divisor;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
        end else begin
          rem <= {rem[62:0], quo[63]};
        end
        quo <= {quo[62:0], !trial[64]};
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
  assign remainder = rem;
endmodule

// ===== rtl/core/rau_datapath.sv =====
module rau_datapath #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  rau_pkg::dp_cmd_t   cmd,
  output rau_pkg::dp_status_t status,
  input  logic [1:0]         operation,
  input  logic [31:0]        a_num,
  input  logic [31:0]        a_den,
  input  logic [31:0]        b_num,
  input  logic [31:0]        b_den,
  output logic [63:0]        res_num,
  output logic [62:0]        res_den,
  output logic               invalid,
  output logic               overflow,
  input  logic               rst
);
  logic [1:0]  opr;
  logic [31:0] an, ad, bn, bd;
  logic        an_s, ad_s, bn_s, bd_s;
  logic [63:0] gx, gy, t1, t2, num, den, prod, g;
  logic [31:0] q1, q2;
  logic        neg, bad;
  logic [63:0] dvd, dvs, q, r;
  logic        dstart, ddone;
  logic [31:0] ma, mb;
  logic        mdone;

  function automatic logic [32:0] field(input logic [31:0] raw);
    logic [31:0] v;
    logic [31:0] m;
    begin
      v = 32'(signed'(raw[OPERAND_WIDTH-1:0]));
      m = v[31] ? (32'd0 - v) : v;
      field = {v[31], m};
    end
  endfunction

  rau_divider u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(dvd), .divisor(dvs),
    .done(ddone), .quotient(q), .remainder(r)
  );

  assign dstart = (cmd.op == rau_pkg::DP_DIVST);

  always_comb begin
    case (cmd.div_sel)
      rau_pkg::DIV_NUM: begin dvd = num;          dvs = g; end
      rau_pkg::DIV_DEN: begin dvd = den;          dvs = g; end
      rau_pkg::DIV_AD:  begin dvd = {32'd0, ad};  dvs = g; end
      rau_pkg::DIV_BD:  begin dvd = {32'd0, bd};  dvs = g; end
      default:          begin dvd = gx;           dvs = gy; end
    endcase
    case (cmd.mul_sel)
      rau_pkg::MUL_AD_BD: begin ma = ad; mb = bd; end
      rau_pkg::MUL_AN_BD: begin ma = an; mb = bd; end
      rau_pkg::MUL_AD_BN: begin ma = ad; mb = bn; end
      rau_pkg::MUL_Q1_BD: begin ma = q1; mb = bd; end
      rau_pkg::MUL_Q2_AN: begin ma = q2; mb = an; end
      rau_pkg::MUL_Q1_BN: begin ma = q1; mb = bn; end
      default:            begin ma = an; mb = bn; end
    endcase
  end

  always_ff @(posedge clk) begin
    mdone <= (cmd.op == rau_pkg::DP_MULST);
    if (cmd.op == rau_pkg::DP_MULST) prod <= {32'd0, ma} * {32'd0, mb};
    case (cmd.op)
      rau_pkg::DP_LOAD: begin
        opr <= operation;
        {an_s, an} <= field(a_num);
        {ad_s, ad} <= field(a_den);
        {bn_s, bn} <= field(b_num);
        {bd_s, bd} <= field(b_den);
      end
      rau_pkg::DP_G1INIT: begin
        gx <= {32'd0, ad};
        gy <= {32'd0, bd};
      end
      rau_pkg::DP_G1STEP, rau_pkg::DP_G2STEP: begin
        gx <= gy;
        gy <= r;
      end
      rau_pkg::DP_GSET: g <= gx;
      rau_pkg::DP_Q1SET: q1 <= q[31:0];
      rau_pkg::DP_Q2SET: q2 <= q[31:0];
      rau_pkg::DP_LSET: den <= prod;
      rau_pkg::DP_T1SET: t1 <= prod;
      rau_pkg::DP_T2SET: t2 <= prod;
      rau_pkg::DP_COMB: begin
        if (((an_s != ad_s) && t1 != 0) == (((bn_s != bd_s) != (opr == rau_pkg::OP_SUB))
            && t2 != 0)) begin
          num <= t1 + t2;
          neg <= (an_s != ad_s) && t1 != 0;
        end else if (t1 >= t2) begin
          num <= t1 - t2;
          neg <= (an_s != ad_s) && t1 != 0;
        end else begin
          num <= t2 - t1;
          neg <= ((bn_s != bd_s) != (opr == rau_pkg::OP_SUB)) && t2 != 0;
        end
      end
      rau_pkg::DP_CROSS: begin
        num <= t1;
        den <= t2;
        if (opr == rau_pkg::OP_MUL) neg <= (an_s != bn_s) != (ad_s != bd_s);
        else neg <= (an_s != bd_s) != (ad_s != bn_s);
      end
      rau_pkg::DP_G2INIT: begin
        gx <= num;
        gy <= den;
      end
      rau_pkg::DP_NUMQ: num <= q;
      rau_pkg::DP_DENQ: den <= q;
      rau_pkg::DP_FINISH: begin
        res_num <= bad ? 64'd1 : ((neg && num != 0) ? 64'd0 - num : num);
        res_den <= bad ? 63'd0 : den[62:0];
        invalid <= bad;
        overflow <= 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    bad = (ad == 0) || (bd == 0) || (opr == rau_pkg::OP_DIV && bn == 0);
  end

  assign status.div_done = ddone;
  assign status.mul_done = mdone;
  assign status.bad = bad;
  assign status.is_addsub = !opr[1];
  assign status.is_div = (opr == rau_pkg::OP_DIV);
  assign status.rem_zero = (gy == 0);
endmodule

// ===== rtl/core/rau_control.sv =====
module rau_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output rau_pkg::dp_cmd_t    cmd,
  input  rau_pkg::dp_status_t status
);
  localparam logic [4:0] S_IDLE = 5'd0, S_CHK = 5'd1, S_G1 = 5'd2, S_G1W = 5'd3,
    S_LD = 5'd4, S_LW = 5'd5, S_T1 = 5'd6, S_T1W = 5'd7, S_T2 = 5'd8, S_T2W = 5'd9,
    S_COMB = 5'd10, S_M1 = 5'd11, S_M1W = 5'd12, S_M2 = 5'd13, S_M2W = 5'd14,
    S_CROSS = 5'd15, S_G2I = 5'd16, S_G2 = 5'd17, S_G2W = 5'd18, S_NQ = 5'd19,
    S_NQW = 5'd20, S_DQ = 5'd21, S_DQW = 5'd22, S_FIN = 5'd23, S_OUT = 5'd24,
    S_BAD = 5'd25, S_Q1 = 5'd26, S_Q1W = 5'd27, S_Q2 = 5'd28, S_Q2W = 5'd29,
    S_LM = 5'd30;
  logic [4:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '{op: rau_pkg::DP_NONE, div_sel: rau_pkg::DIV_GCD, mul_sel: rau_pkg::MUL_AN_BN};
    case (state)
      S_IDLE: if (in_valid) begin cmd.op = rau_pkg::DP_LOAD; state_next = S_CHK; end
      S_CHK: begin
        if (status.bad) state_next = S_BAD;
        else if (status.is_addsub) begin cmd.op = rau_pkg::DP_G1INIT; state_next = S_G1; end
        else state_next = S_M1;
      end
      S_G1: begin
        if (status.rem_zero) state_next = S_LD;
        else begin cmd.op = rau_pkg::DP_DIVST; state_next = S_G1W; end
      end
      S_G1W: if (status.div_done) begin cmd.op = rau_pkg::DP_G1STEP; state_next = S_G1; end
      S_LD: begin cmd.op = rau_pkg::DP_GSET; state_next = S_Q1; end
      S_Q1: begin cmd.op = rau_pkg::DP_DIVST; cmd.div_sel = rau_pkg::DIV_AD;
        state_next = S_Q1W; end
      S_Q1W: if (status.div_done) begin cmd.op = rau_pkg::DP_Q1SET; state_next = S_Q2; end
      S_Q2: begin cmd.op = rau_pkg::DP_DIVST; cmd.div_sel = rau_pkg::DIV_BD;
        state_next = S_Q2W; end
      S_Q2W: if (status.div_done) begin cmd.op = rau_pkg::DP_Q2SET; state_next = S_LM; end
      S_LM: begin cmd.op = rau_pkg::DP_MULST; cmd.mul_sel = rau_pkg::MUL_Q1_BD;
        state_next = S_LW; end
      S_LW: if (status.mul_done) begin cmd.op = rau_pkg::DP_LSET; state_next = S_T1; end
      S_T1: begin cmd.op = rau_pkg::DP_MULST; cmd.mul_sel = rau_pkg::MUL_Q2_AN;
        state_next = S_T1W; end
      S_T1W: if (status.mul_done) begin cmd.op = rau_pkg::DP_T1SET; state_next = S_T2; end
      S_T2: begin cmd.op = rau_pkg::DP_MULST; cmd.mul_sel = rau_pkg::MUL_Q1_BN;
        state_next = S_T2W; end
      S_T2W: if (status.mul_done) begin cmd.op = rau_pkg::DP_T2SET; state_next = S_COMB; end
      S_COMB: begin cmd.op = rau_pkg::DP_COMB; state_next = S_G2I; end
      S_M1: begin cmd.op = rau_pkg::DP_MULST;
        cmd.mul_sel = status.is_div ? rau_pkg::MUL_AN_BD : rau_pkg::MUL_AN_BN;
        state_next = S_M1W; end
      S_M1W: if (status.mul_done) begin cmd.op = rau_pkg::DP_T1SET; state_next = S_M2; end
      S_M2: begin cmd.op = rau_pkg::DP_MULST;
        cmd.mul_sel = status.is_div ? rau_pkg::MUL_AD_BN : rau_pkg::MUL_AD_BD;
        state_next = S_M2W; end
      S_M2W: if (status.mul_done) begin cmd.op = rau_pkg::DP_T2SET; state_next = S_CROSS; end
      S_CROSS: begin cmd.op = rau_pkg::DP_CROSS; state_next = S_G2I; end
      S_G2I: begin cmd.op = rau_pkg::DP_G2INIT; state_next = S_G2; end
      S_G2: begin
        if (status.rem_zero) state_next = S_NQ;
        else begin cmd.op = rau_pkg::DP_DIVST; state_next = S_G2W; end
      end
      S_G2W: if (status.div_done) begin cmd.op = rau_pkg::DP_G2STEP; state_next = S_G2; end
      S_NQ: begin cmd.op = rau_pkg::DP_GSET; state_next = S_NQW; end
      S_NQW: begin cmd.op = rau_pkg::DP_DIVST; cmd.div_sel = rau_pkg::DIV_NUM;
        state_next = S_DQ; end
      S_DQ: if (status.div_done) begin cmd.op = rau_pkg::DP_NUMQ; state_next = S_DQW; end
      S_DQW: begin cmd.op = rau_pkg::DP_DIVST; cmd.div_sel = rau_pkg::DIV_DEN;
        state_next = S_FIN; end
      S_FIN: if (status.div_done) begin cmd.op = rau_pkg::DP_DENQ; state_next = S_BAD; end
      S_BAD: begin cmd.op = rau_pkg::DP_FINISH; state_next = S_OUT; end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// ===== rtl/core/rational_arith_unit.sv =====
// Rational arithmetic unit: takes two signed fractions and an operation
// (add, subtract, multiply, divide), returns the result reduced by gcd with
// sign on the numerator. A zero operand denominator, or divide by zero,
// returns 1/0 with invalid set. One transaction at a time: each gcd step and
// each quotient is a 64-bit division on the shared radix-2 divider. An item
// runs a Euclid gcd of the denominators (add and subtract only) and a
// reduction gcd (every valid operation). Output stall holds the result.
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] res_num,
  output logic [62:0] res_den,
  output logic        invalid,
  output logic        overflow
);
  rau_pkg::dp_cmd_t    cmd;
  rau_pkg::dp_status_t status;

  rau_control u_ctl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
  );

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .operation(operation),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .res_num(res_num), .res_den(res_den), .invalid(invalid), .overflow(overflow)
  );
endmodule

// ===== rtl/core/rau_checker.sv =====
`include "assert_macros.svh"
module rau_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] res_num,
  input logic [62:0] res_den,
  input logic        invalid
);
  `ASSERT_IMPL(a_inv_form, clk, rst, out_valid && invalid, res_num == 64'd1 && res_den == '0)
  `ASSERT_IMPL(a_den_pos, clk, rst, out_valid && !invalid, res_den != '0)
  `ASSERT_IMPL(a_busy, clk, rst, out_valid, in_stall)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(res_num))
endmodule

bind rational_arith_unit rau_checker u_chk (.*);

// ===== dv/rational_arith_unit_test.sv =====
`timescale 1ns / 1ps

module rational_arith_unit_test;
  localparam longint CYCLE_LIMIT = 64'd60_000_000;
  localparam int RANDOM_ITEMS = 1530;
  localparam int QUIET_TAIL = 150;
  localparam int HOLDOFF_CYCLES = 4000;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] an;
    logic [31:0] ad;
    logic [31:0] bn;
    logic [31:0] bd;
    bit          drain_first;
  } fraction_pair_t;

  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    logic        inv;
    logic        ovf;
  } fraction_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = rau_pkg::OP_ADD;
  logic [31:0] a_num = '0;
  logic [31:0] a_den = '0;
  logic [31:0] b_num = '0;
  logic [31:0] b_den = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] res_num;
  logic [62:0] res_den;
  logic        invalid;
  logic        overflow;

  fraction_pair_t   pending_pairs[$];
  fraction_result_t expected_results[$];
  int  total_items = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  invalid_seen = 0;
  int  op_seen[4] = '{0, 0, 0, 0};
  int  send_gap = 0;
  int  recv_gap = 0;
  int  holdoff_left = 0;
  bit  holdoff_done = 1'b0;
  bit  taken = 1'b0;
  longint cycles = 0;

  rational_arith_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_num(res_num), .res_den(res_den), .invalid(invalid), .overflow(overflow)
  );

  always #5 clk = ~clk;

  function automatic void signed_magnitude(input logic [31:0] raw, output bit neg,
                                           output logic [63:0] mag);
    neg = raw[31];
    mag = neg ? (64'd1 << 32) - {32'd0, raw} : {32'd0, raw};
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic fraction_result_t rational_result(input fraction_pair_t p);
    fraction_result_t res;
    bit an_s, ad_s, bn_s, bd_s, neg, s1, s2;
    logic [63:0] an, ad, bn, bd, num, den, g, l, t1, t2;
    signed_magnitude(p.an, an_s, an);
    signed_magnitude(p.ad, ad_s, ad);
    signed_magnitude(p.bn, bn_s, bn);
    signed_magnitude(p.bd, bd_s, bd);
    if (ad == 0 || bd == 0 || (p.op == rau_pkg::OP_DIV && bn == 0)) begin
      res.num = 64'd1;
      res.den = '0;
      res.inv = 1'b1;
      res.ovf = 1'b0;
      return res;
    end
    if (p.op == rau_pkg::OP_ADD || p.op == rau_pkg::OP_SUB) begin
      g = gcd64(ad, bd);
      l = (ad / g) * bd;
      t1 = (l / ad) * an;
      t2 = (l / bd) * bn;
      s1 = an_s != ad_s;
      s2 = (bn_s != bd_s) != (p.op == rau_pkg::OP_SUB);
      if (t1 == 0) s1 = 1'b0;
      if (t2 == 0) s2 = 1'b0;
      if (s1 == s2) begin
        num = t1 + t2;
        neg = s1;
      end else if (t1 >= t2) begin
        num = t1 - t2;
        neg = s1;
      end else begin
        num = t2 - t1;
        neg = s2;
      end
      den = l;
    end else if (p.op == rau_pkg::OP_MUL) begin
      num = an * bn;
      den = ad * bd;
      neg = (an_s != bn_s) != (ad_s != bd_s);
    end else begin
      num = an * bd;
      den = ad * bn;
      neg = (an_s != bd_s) != (ad_s != bn_s);
    end
    g = gcd64(num, den);
    num = num / g;
    den = den / g;
    if (num == 0) neg = 1'b0;
    res.ovf = den[63] || (neg ? num > 64'h8000_0000_0000_0000
                              : num >= 64'h8000_0000_0000_0000);
    res.num = neg ? 64'd0 - num : num;
    res.den = den[62:0];
    res.inv = 1'b0;
    return res;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 20)) - 10);
      3, 4, 5: return 32'(signed'($urandom_range(0, 2000)) - 1000);
      6: return 32'(signed'($urandom_range(0, 200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_pair(input logic [1:0] op, input logic [31:0] an, input logic [31:0] ad,
                          input logic [31:0] bn, input logic [31:0] bd, input bit drain);
    fraction_pair_t p;
    p.op = op;
    p.an = an;
    p.ad = ad;
    p.bn = bn;
    p.bd = bd;
    p.drain_first = drain;
    pending_pairs.push_back(p);
    total_items++;
  endtask

  initial begin
    logic [31:0] den_a, den_b;
    add_pair(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1'b0);
    add_pair(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 1'b0);
    add_pair(rau_pkg::OP_MUL, -32'sd3, 32'd4, 32'd2, -32'sd9, 1'b0);
    add_pair(rau_pkg::OP_DIV, 32'd5, 32'd7, -32'sd10, 32'd21, 1'b0);
    add_pair(rau_pkg::OP_ADD, 32'd1, 32'd0, 32'd1, 32'd2, 1'b0);
    add_pair(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd0, 1'b0);
    add_pair(rau_pkg::OP_MUL, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    add_pair(rau_pkg::OP_DIV, 32'd3, 32'd5, 32'd0, 32'd7, 1'b0);
    add_pair(rau_pkg::OP_DIV, 32'd3, 32'd5, 32'd0, 32'd0, 1'b0);
    add_pair(rau_pkg::OP_MUL, 32'd0, 32'd5, -32'sd7, 32'd3, 1'b0);
    add_pair(rau_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_pair(rau_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    add_pair(rau_pkg::OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1, 1'b0);
    add_pair(rau_pkg::OP_MUL, 32'h7fff_ffff, 32'h8000_0001, 32'h7fff_ffff, 32'd1, 1'b0);
    add_pair(rau_pkg::OP_DIV, 32'h8000_0000, 32'd1, 32'd1, 32'h8000_0000, 1'b0);
    add_pair(rau_pkg::OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_pair(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_fffd, 1'b0);
    add_pair(rau_pkg::OP_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'd1, 32'd1, 1'b0);
    add_pair(rau_pkg::OP_ADD, -32'sd6, 32'd8, 32'd6, -32'sd8, 1'b0);
    add_pair(rau_pkg::OP_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_pair(rau_pkg::OP_ADD, 32'h5555_5555, 32'haaaa_aaab, 32'haaaa_aaaa, 32'h5555_5555, 1'b0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      den_a = pick_value();
      den_b = pick_value();
      if ($urandom_range(0, 24) == 0) den_a = 32'd0;
      if ($urandom_range(0, 24) == 0) den_b = 32'd0;
      add_pair(2'($urandom_range(0, 3)), pick_value(), den_a,
               ($urandom_range(0, 19) == 0) ? 32'd0 : pick_value(), den_b,
               (i == 400 || i == 900));
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  always @(negedge clk) begin
    fraction_pair_t p;
    if (!rst && !(in_valid && !taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_pairs[0].drain_first && (expected_results.size() != 0 || taken)) begin
        in_valid <= 1'b0;
      end else if (items_sent < total_items - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else begin
        p = pending_pairs.pop_front();
        operation <= p.op;
        a_num <= p.an;
        a_den <= p.ad;
        b_num <= p.bn;
        b_den <= p.bd;
        in_valid <= 1'b1;
        items_sent++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!holdoff_done && results_seen >= 150) begin
        holdoff_done <= 1'b1;
        holdoff_left <= HOLDOFF_CYCLES;
        out_stall <= 1'b1;
      end else if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (items_sent < total_items - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
        recv_gap <= $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    fraction_pair_t p;
    fraction_result_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
    taken <= in_valid && !in_stall && !rst;
    if (!rst && in_valid && !in_stall) begin
      p.op = operation;
      p.an = a_num;
      p.ad = a_den;
      p.bn = b_num;
      p.bd = b_den;
      p.drain_first = 1'b0;
      expected_results.push_back(rational_result(p));
      op_seen[operation]++;
    end
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: %h/%h inv=%b ovf=%b",
                   res_num, res_den, invalid, overflow);
      end else begin
        want = expected_results.pop_front();
        if (invalid) invalid_seen++;
        if (res_num !== want.num || res_den !== want.den || invalid !== want.inv ||
            overflow !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: want %h/%h inv=%b ovf=%b, got %h/%h inv=%b ovf=%b",
                     results_seen, want.num, want.den, want.inv, want.ovf,
                     res_num, res_den, invalid, overflow);
        end
      end
    end
  end

  initial begin
    wait (!rst);
    wait (pending_pairs.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d fraction pairs sent (add %0d, sub %0d, mul %0d, div %0d), %0d checked",
             items_sent, op_seen[rau_pkg::OP_ADD], op_seen[rau_pkg::OP_SUB],
             op_seen[rau_pkg::OP_MUL], op_seen[rau_pkg::OP_DIV], results_seen);
    $display("%0d invalid results, %0d mismatches, leftover %0d",
             invalid_seen, mismatches, expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rau_pkg.sv
rtl/core/rau_divider.sv
rtl/core/rau_datapath.sv
rtl/core/rau_control.sv
rtl/core/rational_arith_unit.sv
rtl/core/rau_checker.sv
dv/rational_arith_unit_test.sv
